### hw/rtl/ucs_pkg.sv
// ucs_pkg: shared types and constants of the URI component splitter.
// No dependencies; every other file of the block but ucs_stream_if imports it.
`timescale 1ns / 1ps

package ucs_pkg;

  // Input transaction: one byte with its lookahead, or an end marker
  typedef struct packed {
    logic       kind;
    logic [7:0] char_value;
    logic [7:0] next_char;
    logic       next_valid;
  } ucs_in_t;

  // Output transaction: one result
  typedef struct packed {
    logic [1:0] result_kind;
    logic [2:0] component;
    logic [7:0] data_byte;
    logic [8:0] position;
    logic       overflow;
    logic       last;
  } ucs_out_t;

  // Queue entry: an optional first result, optionally followed by a done result
  typedef struct packed {
    logic       has_first;
    logic       has_done;
    logic [1:0] result_kind;
    logic [2:0] component;
    logic [7:0] data_byte;
    logic [8:0] position;
    logic       overflow;
  } ucs_op_t;

  localparam logic KindChar = 1'b0;
  localparam logic KindEnd  = 1'b1;

  localparam logic [1:0] RkData    = 2'd0;
  localparam logic [1:0] RkClose   = 2'd1;
  localparam logic [1:0] RkDiscard = 2'd2;
  localparam logic [1:0] RkDone    = 2'd3;

  localparam logic [2:0] CompScheme = 3'd0;
  localparam logic [2:0] CompHost   = 3'd1;
  localparam logic [2:0] CompPort   = 3'd2;
  localparam logic [2:0] CompSeg    = 3'd3;
  localparam logic [2:0] CompQuery  = 3'd4;
  localparam logic [2:0] CompFrag   = 3'd5;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChQuest = 8'h3F;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChSpace = 8'h20;

  localparam int unsigned PosW = 9;

endpackage

### hw/rtl/ucs_stream_if.sv
// ucs_stream_if: valid/ready channel carrying one payload struct.
// Payload types come from ucs_pkg at the point of instantiation.
`timescale 1ns / 1ps

interface ucs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/ucs_front.sv
// ucs_front: accepts input transactions, runs the parse state machine and
// pushes up to two results per byte as one queue entry. Depends on ucs_pkg and ucs_stream_if.
`timescale 1ns / 1ps

module ucs_front #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ucs_stream_if.sink       in_i,
  input  logic             full_i,
  output logic             push_o,
  output ucs_pkg::ucs_op_t op_o
);
  import ucs_pkg::*;

  localparam int unsigned PlenW = $clog2(BUFFER_BYTES + 1);
  localparam logic [PlenW-1:0] BufLen = PlenW'(BUFFER_BYTES);

  typedef enum logic [3:0] {
    StInit       = 4'd0,
    StScheme     = 4'd1,
    StFirstSlash = 4'd2,
    StHost       = 4'd3,
    StPort       = 4'd4,
    StSegment    = 4'd5,
    StQuery      = 4'd6,
    StFrag       = 4'd7,
    StFinish     = 4'd8
  } state_e;

  state_e           state_q, state_d;
  logic [PlenW-1:0] plen_q, plen_d;
  logic             ovf_q, ovf_d;

  logic             accept;
  logic             is_end;
  logic             la_slash;
  logic [7:0]       c;
  logic [PosW-1:0]  pos;
  logic [2:0]       cur_comp;
  ucs_op_t          op;

  function automatic ucs_op_t first_res(logic [1:0] k, logic [2:0] comp,
                                        logic [7:0] b, logic [PosW-1:0] p,
                                        logic o);
    ucs_op_t r;
    r             = '0;
    r.has_first   = 1'b1;
    r.result_kind = k;
    r.component   = comp;
    r.data_byte   = b;
    r.position    = p;
    r.overflow    = o;
    return r;
  endfunction

  assign c        = in_i.payload.char_value;
  assign la_slash = in_i.payload.next_valid && (in_i.payload.next_char == ChSlash);
  assign is_end   = (in_i.payload.kind == KindEnd) || (c == ChSpace);
  assign pos      = PosW'(plen_q);
  assign accept   = in_i.valid && in_i.ready;

  assign in_i.ready = !full_i;

  // component a data byte or a discard belongs to
  always_comb begin
    unique case (state_q)
      StScheme:            cur_comp = CompSeg;
      StFirstSlash:        cur_comp = CompHost;
      StHost:              cur_comp = CompHost;
      StPort:              cur_comp = CompPort;
      StSegment:           cur_comp = CompSeg;
      StQuery:             cur_comp = CompQuery;
      StFrag:              cur_comp = CompFrag;
      default:             cur_comp = CompScheme;
    endcase
  end

  always_comb begin
    state_d = state_q;
    plen_d  = plen_q;
    ovf_d   = ovf_q;
    op      = '0;
    if (is_end) begin
      unique case (state_q)
        StInit, StHost: op = first_res(RkClose, CompHost, 8'd0, pos, ovf_q);
        StPort:         op = first_res(RkClose, CompPort, 8'd0, pos, ovf_q);
        StQuery:        op = first_res(RkClose, CompQuery, 8'd0, pos, ovf_q);
        StFrag:         op = first_res(RkClose, CompFrag, 8'd0, pos, ovf_q);
        StScheme, StSegment: begin
          if (plen_q != '0) op = first_res(RkClose, CompSeg, 8'd0, pos, ovf_q);
        end
        default:        op = first_res(RkDiscard, cur_comp, 8'd0, pos, ovf_q);
      endcase
      op.has_done = 1'b1;
      state_d     = StInit;
      plen_d      = '0;
      ovf_d       = 1'b0;
    end else if (c == ChColon) begin
      if (state_q == StInit && la_slash) begin
        op      = first_res(RkClose, CompScheme, 8'd0, pos, ovf_q);
        state_d = StScheme;
        plen_d  = '0;
        ovf_d   = 1'b0;
      end else if (state_q == StInit || state_q == StHost) begin
        op      = first_res(RkClose, CompHost, 8'd0, pos, ovf_q);
        state_d = StPort;
        plen_d  = '0;
        ovf_d   = 1'b0;
      end
    end else if (c == ChSlash) begin
      unique case (state_q)
        StScheme: state_d = la_slash ? StFirstSlash : StSegment;
        StFirstSlash: begin
          op      = first_res(RkDiscard, cur_comp, 8'd0, pos, ovf_q);
          state_d = StHost;
          plen_d  = '0;
          ovf_d   = 1'b0;
        end
        StInit, StHost: begin
          op      = first_res(RkClose, CompHost, 8'd0, pos, ovf_q);
          state_d = StSegment;
          plen_d  = '0;
          ovf_d   = 1'b0;
        end
        StPort: begin
          op      = first_res(RkClose, CompPort, 8'd0, pos, ovf_q);
          state_d = StSegment;
          plen_d  = '0;
          ovf_d   = 1'b0;
        end
        StSegment: begin
          // empty segments are dropped
          if (plen_q != '0) op = first_res(RkClose, CompSeg, 8'd0, pos, ovf_q);
          plen_d = '0;
          ovf_d  = 1'b0;
        end
        default: ;
      endcase
    end else if (c == ChQuest) begin
      unique case (state_q)
        StHost: op = first_res(RkClose, CompHost, 8'd0, pos, ovf_q);
        StPort: op = first_res(RkClose, CompPort, 8'd0, pos, ovf_q);
        StScheme, StSegment: begin
          if (plen_q != '0) op = first_res(RkClose, CompSeg, 8'd0, pos, ovf_q);
        end
        default: op = first_res(RkDiscard, cur_comp, 8'd0, pos, ovf_q);
      endcase
      state_d = StQuery;
      plen_d  = '0;
      ovf_d   = 1'b0;
    end else if (c == ChHash) begin
      unique case (state_q)
        StQuery: op = first_res(RkClose, CompQuery, 8'd0, pos, ovf_q);
        StSegment: begin
          if (plen_q != '0) op = first_res(RkClose, CompSeg, 8'd0, pos, ovf_q);
        end
        StHost:  op = first_res(RkClose, CompHost, 8'd0, pos, ovf_q);
        StPort:  op = first_res(RkClose, CompPort, 8'd0, pos, ovf_q);
        default: op = first_res(RkDiscard, cur_comp, 8'd0, pos, ovf_q);
      endcase
      state_d = StFrag;
      plen_d  = '0;
      ovf_d   = 1'b0;
    end else begin
      if (plen_q >= BufLen) begin
        // buffer full: byte dropped but still reported
        op     = first_res(RkData, cur_comp, c, PosW'(BufLen), 1'b1);
        plen_d = BufLen;
        ovf_d  = 1'b1;
      end else begin
        op     = first_res(RkData, cur_comp, c, pos, ovf_q);
        plen_d = plen_q + 1'b1;
      end
    end
  end

  assign push_o = accept && (op.has_first || op.has_done);
  assign op_o   = op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      plen_q  <= '0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      state_q <= state_d;
      plen_q  <= plen_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

### hw/rtl/ucs_queue.sv
// ucs_queue: small FIFO of result entries between front and back.
// Depends on ucs_pkg for the entry type.
`timescale 1ns / 1ps

module ucs_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ucs_pkg::ucs_op_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output ucs_pkg::ucs_op_t data_o
);
  import ucs_pkg::*;

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(DEPTH - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(DEPTH);

  ucs_op_t          mem_q [DEPTH];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/ucs_back.sv
// ucs_back: expands queue entries into result transactions through an
// output register. Depends on ucs_pkg and ucs_stream_if.
`timescale 1ns / 1ps

module ucs_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  ucs_pkg::ucs_op_t op_i,
  output logic             pop_o,
  ucs_stream_if.source     out_o
);
  import ucs_pkg::*;

  ucs_out_t out_q, out_d;
  logic     out_valid_q;
  logic     first_sent_q, first_sent_d;
  logic     load;
  logic     emit_first;

  // output register takes a new result whenever it is empty or being drained
  assign load       = !out_valid_q || out_o.ready;
  assign emit_first = op_i.has_first && !first_sent_q;

  always_comb begin
    out_d        = out_q;
    first_sent_d = first_sent_q;
    pop_o        = 1'b0;
    if (load && !empty_i) begin
      if (emit_first) begin
        out_d.result_kind = op_i.result_kind;
        out_d.component   = op_i.component;
        out_d.data_byte   = op_i.data_byte;
        out_d.position    = op_i.position;
        out_d.overflow    = op_i.overflow;
        out_d.last        = !op_i.has_done;
        if (op_i.has_done) begin
          first_sent_d = 1'b1;
        end else begin
          pop_o = 1'b1;
        end
      end else begin
        out_d        = '0;
        out_d.result_kind = RkDone;
        out_d.last   = 1'b1;
        first_sent_d = 1'b0;
        pop_o        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      first_sent_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= !empty_i;
      end
      first_sent_q <= first_sent_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

### hw/rtl/uri_component_splitter_unit.sv
// Channel  | Dir | Payload               | Transaction
// ---------+-----+-----------------------+---------------------------------------
// in_i     | in  | ucs_pkg::ucs_in_t     | one URI byte with lookahead, or end
// out_o    | out | ucs_pkg::ucs_out_t    | one result: data, close, discard, done
//
// Cycles: one input byte per cycle; the parse state updates in the cycle the
// byte is taken. Bytes that give one result stream at one per cycle while the
// output is ready; an end that closes a component gives a close, then a done.
// The QUEUE_DEPTH entry queue between parser and output register absorbs
// output stalls; input stalls only when it is full. Reset clears the parse
// state and the queue; no clearing pass is needed.
// Top level of the URI component splitter. Depends on ucs_pkg, ucs_stream_if,
// ucs_front, ucs_queue and ucs_back.
`timescale 1ns / 1ps

module uri_component_splitter_unit #(
  parameter int unsigned BUFFER_BYTES = 256,
  parameter int unsigned QUEUE_DEPTH  = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ucs_stream_if.sink   in_i,
  ucs_stream_if.source out_o
);
  import ucs_pkg::*;

  ucs_op_t push_op, head_op;
  logic    push, pop, full, empty;

  ucs_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .full_i(full),
    .push_o(push),
    .op_o  (push_op)
  );

  ucs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_op),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (head_op)
  );

  ucs_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(empty),
    .op_i   (head_op),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

### dv/ucs_checker.sv
// ucs_checker: watches both channels of the URI component splitter, predicts
// every result from the accepted input transactions and compares in order.
// Depends on ucs_pkg.
`timescale 1ns / 1ps

module ucs_checker #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  ucs_pkg::ucs_in_t  in_item_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  ucs_pkg::ucs_out_t out_item_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o,
  output int                uris_o,
  output int                overflows_o
);
  import ucs_pkg::*;

  typedef enum logic [3:0] {
    PsInit, PsScheme, PsFirstSlash, PsHost, PsPort, PsSeg, PsQuery, PsFrag, PsFinish
  } parse_st_e;

  parse_st_e  pstate;
  logic [8:0] plen;
  logic       ovf_seen;
  ucs_out_t   expect_q[$];

  // component that a data byte or a discard in the current state belongs to
  function automatic logic [2:0] comp_of(parse_st_e s);
    case (s)
      PsScheme, PsSeg:     return CompSeg;
      PsFirstSlash, PsHost: return CompHost;
      PsPort:              return CompPort;
      PsQuery:             return CompQuery;
      PsFrag:              return CompFrag;
      default:             return CompScheme;
    endcase
  endfunction

  function automatic ucs_out_t mk(logic [1:0] rk, logic [2:0] comp, logic [7:0] b,
                                  logic [8:0] pos, logic ov);
    ucs_out_t r;
    r.result_kind = rk;
    r.component   = comp;
    r.data_byte   = b;
    r.position    = pos;
    r.overflow    = ov;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic ucs_out_t closed(logic [2:0] comp);
    return mk(RkClose, comp, 8'd0, plen, ovf_seen);
  endfunction

  function automatic ucs_out_t dropped();
    return mk(RkDiscard, comp_of(pstate), 8'd0, plen, ovf_seen);
  endfunction

  task automatic restart(parse_st_e s);
    pstate   = s;
    plen     = '0;
    ovf_seen = 1'b0;
  endtask

  task automatic predict_split(ucs_in_t it);
    ucs_out_t res[$];
    logic     la_slash;
    logic [7:0] c;
    c        = it.char_value;
    la_slash = it.next_valid && (it.next_char == ChSlash);
    if (it.kind == KindEnd || c == ChSpace) begin
      case (pstate)
        PsInit, PsHost:  res.push_back(closed(CompHost));
        PsPort:          res.push_back(closed(CompPort));
        PsQuery:         res.push_back(closed(CompQuery));
        PsFrag:          res.push_back(closed(CompFrag));
        PsScheme, PsSeg: if (plen != 0) res.push_back(closed(CompSeg));
        default:         res.push_back(dropped());
      endcase
      res.push_back(mk(RkDone, CompScheme, 8'd0, 9'd0, 1'b0));
      restart(PsInit);
    end else if (c == ChColon) begin
      if (pstate == PsInit && la_slash) begin
        res.push_back(closed(CompScheme));
        restart(PsScheme);
      end else if (pstate == PsInit || pstate == PsHost) begin
        res.push_back(closed(CompHost));
        restart(PsPort);
      end
    end else if (c == ChSlash) begin
      case (pstate)
        // pending text survives the move out of the scheme state
        PsScheme: pstate = la_slash ? PsFirstSlash : PsSeg;
        PsFirstSlash: begin
          res.push_back(dropped());
          restart(PsHost);
        end
        PsInit, PsHost: begin
          res.push_back(closed(CompHost));
          restart(PsSeg);
        end
        PsPort: begin
          res.push_back(closed(CompPort));
          restart(PsSeg);
        end
        PsSeg: begin
          if (plen != 0) res.push_back(closed(CompSeg));
          restart(PsSeg);
        end
        default: ;
      endcase
    end else if (c == ChQuest) begin
      case (pstate)
        PsHost:          res.push_back(closed(CompHost));
        PsPort:          res.push_back(closed(CompPort));
        PsScheme, PsSeg: if (plen != 0) res.push_back(closed(CompSeg));
        default:         res.push_back(dropped());
      endcase
      restart(PsQuery);
    end else if (c == ChHash) begin
      case (pstate)
        PsQuery: res.push_back(closed(CompQuery));
        PsSeg:   if (plen != 0) res.push_back(closed(CompSeg));
        PsHost:  res.push_back(closed(CompHost));
        PsPort:  res.push_back(closed(CompPort));
        default: res.push_back(dropped());
      endcase
      restart(PsFrag);
    end else if (plen >= BUFFER_BYTES) begin
      // buffer full: byte is reported but not kept
      plen     = 9'(BUFFER_BYTES);
      ovf_seen = 1'b1;
      res.push_back(mk(RkData, comp_of(pstate), c, plen, 1'b1));
    end else begin
      res.push_back(mk(RkData, comp_of(pstate), c, plen, ovf_seen));
      plen = plen + 9'd1;
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) expect_q.push_back(res[i]);
  endtask

  task automatic check_result(ucs_out_t got);
    ucs_out_t exp;
    if (expect_q.size() == 0) begin
      fail_count_o++;
      $display("%0t: unexpected result kind=%0d comp=%0d byte=%02h pos=%0d ovf=%0b last=%0b",
               $time, got.result_kind, got.component, got.data_byte, got.position,
               got.overflow, got.last);
      return;
    end
    exp = expect_q.pop_front();
    checked_o++;
    if (got.result_kind == RkDone) uris_o++;
    if (got.overflow) overflows_o++;
    if (got.result_kind !== exp.result_kind || got.component !== exp.component ||
        got.data_byte !== exp.data_byte || got.position !== exp.position ||
        got.overflow !== exp.overflow || got.last !== exp.last) begin
      fail_count_o++;
      $display("%0t: mismatch expected kind=%0d comp=%0d byte=%02h pos=%0d ovf=%0b last=%0b",
               $time, exp.result_kind, exp.component, exp.data_byte, exp.position,
               exp.overflow, exp.last);
      $display("%0t:          actual   kind=%0d comp=%0d byte=%02h pos=%0d ovf=%0b last=%0b",
               $time, got.result_kind, got.component, got.data_byte, got.position,
               got.overflow, got.last);
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    uris_o       = 0;
    overflows_o  = 0;
    restart(PsInit);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart(PsInit);
      expect_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) predict_split(in_item_i);
      if (out_valid_i && out_ready_i) check_result(out_item_i);
    end
    pending_o = expect_q.size();
  end

endmodule

### dv/uri_component_splitter_unit_tb.sv
// uri_component_splitter_unit_tb: drives URI byte streams into the splitter
// with bursty input and a stalling output; verdict from ucs_checker.
// Depends on ucs_pkg, ucs_stream_if, uri_component_splitter_unit, ucs_checker.
`timescale 1ns / 1ps

module uri_component_splitter_unit_tb;
  import ucs_pkg::*;

  localparam int ClkHalf   = 5;
  localparam int BufBytes  = 256;
  localparam int Target    = 1900;
  localparam int HoldCyc   = 300;
  localparam int IdleLimit = 3000;
  localparam int Drain     = 20;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #ClkHalf clk_i = ~clk_i;

  ucs_stream_if #(.payload_t(ucs_in_t))  in_ch ();
  ucs_stream_if #(.payload_t(ucs_out_t)) out_ch ();

  uri_component_splitter_unit #(.BUFFER_BYTES(BufBytes)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  int fail_count, pending, checked, uris, overflows;

  ucs_checker #(.BUFFER_BYTES(BufBytes)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_item_i    (in_ch.payload),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_item_i   (out_ch.payload),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .uris_o       (uris),
    .overflows_o  (overflows)
  );

  int         items_sent = 0;
  int         burst_left = 0;
  bit         hold_req   = 0;
  bit         la_noise   = 0;
  logic [7:0] uri_q[$];

  // ---------------- receiver: own stall pattern plus one long hold-off
  initial begin
    int          stall_cnt;
    logic [10:0] phase;
    stall_cnt = 0;
    phase     = '0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      phase = phase + 11'd1;
      if (stall_cnt != 0) begin
        out_ch.ready <= 1'b0;
        stall_cnt--;
      end else if (hold_req) begin
        hold_req = 0;
        stall_cnt = HoldCyc;
        out_ch.ready <= 1'b0;
      end else begin
        case (phase[10:9])
          2'd0: out_ch.ready <= 1'b1;
          2'd1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2'd2: out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= (phase[2:0] != 3'd5);
        endcase
      end
    end
  end

  // ---------------- watchdog: cycles with no transaction on either channel
  always @(posedge clk_i) begin
    int idle;
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("timeout after %0d idle cycles, %0d results outstanding", idle, pending);
        $display("FAILED: results differ");
        $finish;
      end
    end else begin
      idle = 0;
    end
  end

  // ---------------- stimulus helpers
  function automatic ucs_in_t mk_in(logic k, logic [7:0] c, logic [7:0] nc, logic nv);
    ucs_in_t it;
    it.kind       = k;
    it.char_value = c;
    it.next_char  = nc;
    it.next_valid = nv;
    return it;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == ChColon || c == ChSlash || c == ChQuest || c == ChHash || c == ChSpace);
    return c;
  endfunction

  function automatic logic [7:0] noisy_char();
    case ($urandom_range(0, 7))
      0: return ChColon;
      1: return ChSlash;
      2: return ChQuest;
      3: return ChHash;
      4: return ($urandom_range(0, 2) == 0) ? ChSpace : plain_char();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // bursts of random length, random gaps between them
  task automatic push_item(ucs_in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  task automatic add_text(int lo, int hi);
    int n;
    n = $urandom_range(lo, hi);
    if ($urandom_range(0, 299) == 0) n = $urandom_range(250, 262);
    repeat (n) uri_q.push_back(plain_char());
  endtask

  task automatic load_text(string s);
    uri_q.delete();
    for (int i = 0; i < s.len(); i++) uri_q.push_back(s[i]);
  endtask

  // sends uri_q with true lookahead (noisy when la_noise is set), closed by an end marker or a space
  task automatic send_uri(bit use_marker);
    logic [7:0] nc;
    logic       nv;
    if (!use_marker) uri_q.push_back(ChSpace);
    for (int i = 0; i < uri_q.size(); i++) begin
      nv = (i + 1 < uri_q.size());
      nc = nv ? uri_q[i + 1] : 8'($urandom_range(0, 255));
      if (la_noise && $urandom_range(0, 11) == 0) begin
        nv = 1'($urandom_range(0, 1));
        nc = noisy_char();
      end
      push_item(mk_in(KindChar, uri_q[i], nc, nv));
    end
    if (use_marker)
      push_item(mk_in(KindEnd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1))));
  endtask

  // scheme / authority / path / query / fragment with random content
  task automatic gen_uri();
    int form;
    uri_q.delete();
    form = $urandom_range(0, 4);
    if (form <= 2) begin
      add_text(1, 5);
      uri_q.push_back(ChColon);
    end
    case (form)
      0: begin
        uri_q.push_back(ChSlash);
        uri_q.push_back(ChSlash);
        add_text(0, 6);
        if ($urandom_range(0, 1)) begin
          uri_q.push_back(ChColon);
          add_text(0, 4);
        end
      end
      1: uri_q.push_back(ChSlash);
      3: begin
        add_text(0, 6);
        if ($urandom_range(0, 1)) begin
          uri_q.push_back(ChColon);
          add_text(0, 4);
        end
      end
      default: ;
    endcase
    repeat ($urandom_range(0, 4)) begin
      uri_q.push_back(ChSlash);
      add_text(0, 5);
    end
    if ($urandom_range(0, 2) == 0) begin
      uri_q.push_back(ChQuest);
      add_text(0, 6);
    end
    if ($urandom_range(0, 2) == 0) begin
      uri_q.push_back(ChHash);
      add_text(0, 6);
    end
  endtask

  task automatic send_noise(int n);
    repeat (n)
      push_item(mk_in(($urandom_range(0, 19) == 0) ? KindEnd : KindChar, noisy_char(),
                      noisy_char(), 1'($urandom_range(0, 1))));
  endtask

  // ---------------- main sequence
  initial begin
    bit hold_done;
    hold_done = 0;
    rst_ni        <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: full URI with empty segment, scheme then single slash, edge bytes
    load_text("a://h:1/b//c?d#e");
    send_uri(1'b1);
    load_text("s:/x");
    send_uri(1'b0);
    push_item(mk_in(KindChar, 8'hFF, 8'h00, 1'b0));
    push_item(mk_in(KindChar, 8'h00, 8'hFF, 1'b1));
    // colon before a slash that is not a valid lookahead: host, not scheme
    push_item(mk_in(KindChar, ChColon, ChSlash, 1'b0));
    // end marker wins over the delimiter in the byte field
    push_item(mk_in(KindEnd, ChColon, ChSlash, 1'b1));

    // host longer than the buffer
    uri_q.delete();
    repeat (BufBytes + 3) uri_q.push_back(plain_char());
    uri_q.push_back(ChSlash);
    send_uri(1'b1);

    la_noise = 1;
    while (items_sent < Target) begin
      if ($urandom_range(0, 9) < 8) begin
        gen_uri();
        send_uri(1'($urandom_range(0, 1)));
      end else begin
        send_noise($urandom_range(1, 12));
      end
      if (!hold_done && items_sent > 600) begin
        hold_req  = 1;
        hold_done = 1;
      end
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);

    $display("Run covered %0d input transactions and %0d results, %0d URIs ended,",
             items_sent, checked, uris);
    $display("%0d results flagged overflow, one long output hold-off.", overflows);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
